// ===== src/sbss_pkg.sv =====
// Shared types and constants for the sparse byte signature scan.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package sbss_pkg;

  localparam int LANES      = 8;   // pattern entries carried in the packed registers
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 64;
  localparam int POS_W      = 33;
  localparam int LIMIT_W    = 32;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE      = 3'd0,
    REG_PAT_BYTES = 3'd1,
    REG_PAT_OFFS  = 3'd2,
    REG_PAT_COUNT = 3'd3,
    REG_LIMIT     = 3'd4
  } cfg_reg_t;

  // Settings derived from the registers, as the cell row and the judge stage see them
  typedef struct packed {
    logic [LANES-1:0]             use_mask;  // entries in use
    logic [LANES-1:0][BYTE_W-1:0] lag;       // delay of each entry behind the newest byte
    logic [LANES-1:0][BYTE_W-1:0] pat;       // expected byte of each entry
    logic [BYTE_W-1:0]            maxoff;    // largest offset in use
    logic                         off_ok;    // largest offset fits in the window
    logic [POS_W-1:0]             reach;     // search limit plus largest offset
    logic [ADDR_W-1:0]            base_adj;  // base address minus largest offset
  } scan_cfg_t;

endpackage

`default_nettype wire

// ===== src/sbss_cfg.sv =====
// Configuration registers and the settings derived from them, two register stages deep.
// Depends on sbss_pkg.
`default_nettype none

module sbss_cfg #(
  parameter int WINDOW_DEPTH = 256,
  parameter int MAX_PATTERN  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wen,
  input  wire logic [sbss_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [sbss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sbss_pkg::scan_cfg_t                   cfg_o
);

  logic [sbss_pkg::ADDR_W-1:0]  base_r;
  logic [sbss_pkg::LANES-1:0][sbss_pkg::BYTE_W-1:0] pbytes_r;
  logic [sbss_pkg::LANES-1:0][sbss_pkg::BYTE_W-1:0] poffs_r;
  logic [sbss_pkg::COUNT_W-1:0] count_r;
  logic [sbss_pkg::LIMIT_W-1:0] limit_r;

  logic [sbss_pkg::LANES-1:0]   use_nxt, use_r;
  logic [sbss_pkg::BYTE_W-1:0]  maxoff_nxt, maxoff_r;
  logic [sbss_pkg::COUNT_W-1:0] n_eff;
  sbss_pkg::scan_cfg_t          cfg_nxt, cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      pbytes_r <= '0;
      poffs_r  <= '0;
      count_r  <= sbss_pkg::COUNT_W'(1);
      limit_r  <= '0;
    end else if (cfg_wen) begin
      unique case (sbss_pkg::cfg_reg_t'(cfg_addr))
        sbss_pkg::REG_BASE:      base_r   <= cfg_wdata;
        sbss_pkg::REG_PAT_BYTES: pbytes_r <= cfg_wdata;
        sbss_pkg::REG_PAT_OFFS:  poffs_r  <= cfg_wdata;
        sbss_pkg::REG_PAT_COUNT: count_r  <= cfg_wdata[sbss_pkg::COUNT_W-1:0];
        sbss_pkg::REG_LIMIT:     limit_r  <= cfg_wdata[sbss_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // First stage: entries in use and the largest offset among them
  always_comb begin
    if (count_r == '0) begin
      n_eff = sbss_pkg::COUNT_W'(1);
    end else if (count_r > sbss_pkg::COUNT_W'(MAX_PATTERN)) begin
      n_eff = sbss_pkg::COUNT_W'(MAX_PATTERN);
    end else begin
      n_eff = count_r;
    end
    maxoff_nxt = '0;
    for (int j = 0; j < sbss_pkg::LANES; j++) begin
      use_nxt[j] = (sbss_pkg::COUNT_W'(j) < n_eff);
      if (use_nxt[j] && (poffs_r[j] > maxoff_nxt)) begin
        maxoff_nxt = poffs_r[j];
      end
    end
  end

  // Second stage: delays, reach and adjusted base
  always_comb begin
    cfg_nxt.use_mask = use_r;
    cfg_nxt.pat      = pbytes_r;
    cfg_nxt.maxoff   = maxoff_r;
    for (int j = 0; j < sbss_pkg::LANES; j++) begin
      cfg_nxt.lag[j] = maxoff_r - poffs_r[j];
    end
    cfg_nxt.off_ok   = ({1'b0, maxoff_r} < (sbss_pkg::BYTE_W + 1)'(WINDOW_DEPTH));
    cfg_nxt.reach    = {1'b0, limit_r} + sbss_pkg::POS_W'(maxoff_r);
    cfg_nxt.base_adj = base_r - sbss_pkg::ADDR_W'(maxoff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r    <= sbss_pkg::LANES'(1);
      maxoff_r <= '0;
      cfg_r    <= '{use_mask: sbss_pkg::LANES'(1), lag: '0, pat: '0, maxoff: '0,
                    off_ok: 1'b1, reach: '0, base_adj: '0};
    end else begin
      use_r    <= use_nxt;
      maxoff_r <= maxoff_nxt;
      cfg_r    <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== src/sbss_cell.sv =====
// One window cell: holds one byte of the stream, hands it on, flags mismatching entries.
// Depends on sbss_pkg.
`default_nettype none

module sbss_cell #(
  parameter int IDX = 0
) (
  input  wire logic                             clk,
  input  wire logic                             shift_en,
  input  wire logic [sbss_pkg::BYTE_W-1:0]      byte_i,
  input  wire sbss_pkg::scan_cfg_t              cfg_i,
  output logic [sbss_pkg::BYTE_W-1:0]           byte_o,
  output logic [sbss_pkg::LANES-1:0]            miss_o
);

  logic [sbss_pkg::BYTE_W-1:0] byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_i;
    end
  end

  // An entry lands on this cell when its delay equals the cell's place in the row
  always_comb begin
    for (int j = 0; j < sbss_pkg::LANES; j++) begin
      miss_o[j] = cfg_i.use_mask[j] && (cfg_i.lag[j] == sbss_pkg::BYTE_W'(IDX)) &&
                  (byte_r != cfg_i.pat[j]);
    end
  end

  assign byte_o = byte_r;

endmodule

`default_nettype wire

// ===== src/sparse_byte_signature_scan_top.sv =====
// Top level of the sparse byte signature scan: cell row, mismatch tree, judge and result register.
// Depends on sbss_pkg, sbss_cfg and sbss_cell.
//
//  port group   direction  content
//  in_*         slave      one memory byte per transfer, tlast on the final byte
//  out_*        master     one result per stream: found flag and match address
//  cfg_*        write      register index and data, taken on any cycle with cfg_wen
//
// One byte per cycle is sustained while no configuration write or waiting result holds in_tready low;
// out_tvalid rises once the byte has passed the cell row, registered mismatch tree and result register.
// Stall the pipeline only when a new result meets one still waiting on out_tready.
// Reset clears the control state and loads the register reset values; window bytes are
// not cleared. A configuration write holds in_tready low while cfg_wen or its registered copy is high.
`default_nettype none

module sparse_byte_signature_scan_top #(
  parameter int WINDOW_DEPTH = 256,
  parameter int MAX_PATTERN  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  wire logic                             in_tlast,   // last_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [63:0]                           out_tdata,  // [63:0] match_address
  output logic [0:0]                            out_tuser,  // [0] found
  input  wire logic                             cfg_wen,
  input  wire logic [sbss_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [sbss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int GROUP  = 16;
  localparam int NGRP   = (WINDOW_DEPTH + GROUP - 1) / GROUP;
  localparam int PADDED = NGRP * GROUP;
  localparam logic [sbss_pkg::POS_W-1:0] POS_MAX = '1;

  sbss_pkg::scan_cfg_t cfg;

  logic adv, accept, out_en, cfg_busy_r;
  logic [sbss_pkg::BYTE_W-1:0] cell_byte [WINDOW_DEPTH];
  logic [sbss_pkg::LANES-1:0]  cell_miss [PADDED];
  logic [sbss_pkg::LANES-1:0]  grp_nxt   [NGRP];
  logic [sbss_pkg::LANES-1:0]  grp_r     [NGRP];

  logic [sbss_pkg::POS_W-1:0]  pos_r, pos_nxt, pos0_r;
  logic                        v0_r, last0_r;
  logic                        v1_r, last1_r, ok1_r;
  logic [sbss_pkg::ADDR_W-1:0] addr1_r;
  logic                        fin_r, fin_nxt;
  logic                        any_miss, hit, emit;
  logic                        out_valid_r, out_found_r;
  logic [sbss_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;

  sbss_cfg #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_PATTERN  (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // The result register takes a new value when empty or draining; the pipeline moves on
  // unless stage one has a result for a register that is still full
  assign out_en    = !out_valid_r || out_tready;
  assign adv       = out_en || !emit;
  // Hold the input while the derived settings catch up with a write
  assign in_tready = adv && !cfg_wen && !cfg_busy_r;
  assign accept    = in_tvalid && in_tready;

  // Cell row: cell 0 holds the newest byte, each transfer moves every byte one cell on
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic [sbss_pkg::BYTE_W-1:0] feed;
    if (k == 0) begin : g_head
      assign feed = in_tdata;
    end else begin : g_link
      assign feed = cell_byte[k-1];
    end
    sbss_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_i   (feed),
      .cfg_i    (cfg),
      .byte_o   (cell_byte[k]),
      .miss_o   (cell_miss[k])
    );
  end

  for (genvar k = WINDOW_DEPTH; k < PADDED; k++) begin : g_pad
    assign cell_miss[k] = '0;
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int i = 0; i < GROUP; i++) begin
        grp_nxt[g] = grp_nxt[g] | cell_miss[g*GROUP + i];
      end
    end
  end

  always_comb begin
    if (in_tlast) begin
      pos_nxt = '0;
    end else if (pos_r == POS_MAX) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + sbss_pkg::POS_W'(1);
    end
  end

  // Judge: every entry matched, candidate inside the limit, no hit yet in this stream
  always_comb begin
    any_miss = 1'b0;
    for (int g = 0; g < NGRP; g++) begin
      any_miss = any_miss | (|grp_r[g]);
    end
    hit  = v1_r && ok1_r && !any_miss && !fin_r;
    emit = v1_r && !fin_r && (hit || last1_r);
    if (v1_r) begin
      fin_nxt = last1_r ? 1'b0 : (fin_r || hit);
    end else begin
      fin_nxt = fin_r;
    end
    out_addr_nxt = hit ? addr1_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_busy_r  <= 1'b0;
    end else begin
      cfg_busy_r <= cfg_wen;
      if (adv) begin
        v0_r  <= accept;
        v1_r  <= v0_r;
        fin_r <= fin_nxt;
        if (accept) begin
          pos_r <= pos_nxt;
        end
      end
      if (out_en) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last0_r     <= in_tlast;
      pos0_r      <= pos_r;
      last1_r     <= last0_r;
      ok1_r       <= cfg.off_ok && (pos0_r >= sbss_pkg::POS_W'(cfg.maxoff)) &&
                     (pos0_r <= cfg.reach);
      addr1_r     <= cfg.base_adj + sbss_pkg::ADDR_W'(pos0_r);
      grp_r       <= grp_nxt;
    end
    if (out_en) begin
      out_found_r <= hit;
      out_addr_r  <= out_addr_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_addr_r;
  assign out_tuser[0] = out_found_r;

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen |-> !(in_tvalid && in_tready))
    else $error("byte taken during a configuration write");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v0_r)
    else $error("accepted byte did not enter the pipeline");

  a_quiet_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_en && v1_r && fin_r) |=> !out_valid_r)
    else $error("result given after a hit in the same stream");

  a_fin_from_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> (out_valid_r && out_found_r))
    else $error("finished flag set without a hit result");

  a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_addr_r == '0))
    else $error("not-found result carries an address");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for sparse_byte_signature_scan_top: a directed table, then random
// byte streams with planted and damaged signatures, checked against an in-bench predictor.
// Depends on sbss_pkg and the RTL under src; needs no files or arguments at run time.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = 256;
  localparam int PATTERN_MAX  = 8;
  localparam int RANDOM_ITEMS = 730;
  localparam int DRAIN        = 8;
  localparam int IDLE_PCT     = 13;

  // indexes past the register list; writes to them must change nothing
  localparam logic [sbss_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [sbss_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
  } scan_result_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;
  typedef enum logic [1:0] {OUT_MODEL, OUT_NONE, OUT_HIT, OUT_MISS} outcome_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [sbss_pkg::CFG_IDX_W-1:0]   idx;
    logic [sbss_pkg::CFG_DATA_W-1:0]  value;  // register data, or the byte in bits 7:0
    logic                             last;
    outcome_t                         how;
    logic [63:0]                      addr;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_wen = 1'b0;
  logic [sbss_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [sbss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and register shadows, at their reset values
  logic [63:0] cfg_base = '0;
  logic [63:0] cfg_pat = '0;
  logic [63:0] cfg_offs = '0;
  logic [3:0]  cfg_count = 4'd1;
  logic [31:0] cfg_limit = '0;
  logic [7:0]  byte_window [WINDOW];
  logic [32:0] scan_pos = '0;
  bit          hunt_done = 1'b0;

  scan_result_t pending_results [$];
  bit steady = 1'b0;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned streams_done = 0;
  int unsigned hits_seen = 0;
  int unsigned misses_seen = 0;

  sparse_byte_signature_scan_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic step_row_t cfg_row(logic [sbss_pkg::CFG_IDX_W-1:0] idx,
                                        logic [63:0] value);
    step_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.value = value;
    r.how = OUT_NONE;
    return r;
  endfunction

  function automatic step_row_t byte_row(logic [7:0] b, logic last, outcome_t how,
                                         logic [63:0] addr);
    step_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.value = {56'b0, b};
    r.last = last;
    r.how = how;
    r.addr = addr;
    return r;
  endfunction

  // Advance the predictor by one byte; returns 1 when the byte yields a result.
  function automatic bit scan_byte(logic [7:0] b, logic last, output scan_result_t res);
    int unsigned n;
    int unsigned maxoff;
    int unsigned j;
    logic [32:0] p;
    bit hit;
    bit produced;
    res = '0;
    hit = 1'b0;
    produced = 1'b0;
    if (!hunt_done) begin
      byte_window[scan_pos % WINDOW] = b;
      n = (cfg_count == 0) ? 1 : (cfg_count > PATTERN_MAX) ? PATTERN_MAX : cfg_count;
      maxoff = 0;
      for (j = 0; j < n; j++)
        if (cfg_offs[8*j +: 8] > maxoff) maxoff = cfg_offs[8*j +: 8];
      // judge the candidate whose furthest byte just arrived
      if (maxoff < WINDOW && scan_pos >= maxoff) begin
        p = scan_pos - maxoff;
        if (p <= {1'b0, cfg_limit}) begin
          hit = 1'b1;
          for (j = 0; j < n; j++)
            if (byte_window[(p + cfg_offs[8*j +: 8]) % WINDOW] != cfg_pat[8*j +: 8])
              hit = 1'b0;
        end
      end
      if (hit) begin
        res.found = 1'b1;
        res.addr = cfg_base + {31'b0, p};
        hunt_done = 1'b1;
        produced = 1'b1;
      end else if (last) begin
        produced = 1'b1;
      end
      if (scan_pos != '1) scan_pos++;
    end
    if (last) begin
      scan_pos = '0;
      hunt_done = 1'b0;
    end
    return produced;
  endfunction

  // Entered and left at a falling edge; tvalid stays high on return.
  task automatic send_byte(logic [7:0] b, logic last, outcome_t how, logic [63:0] addr);
    scan_result_t res;
    bit produced;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    produced = scan_byte(b, last, res);
    case (how)
      OUT_NONE: produced = 1'b0;
      OUT_HIT: begin
        produced = 1'b1;
        res.found = 1'b1;
        res.addr = addr;
      end
      OUT_MISS: begin
        produced = 1'b1;
        res = '0;
      end
      default: ;
    endcase
    if (produced) pending_results.push_back(res);
    bytes_sent++;
    if (last) streams_done++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is in and the pipeline has flushed.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(logic [sbss_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      sbss_pkg::REG_BASE:      cfg_base = value;
      sbss_pkg::REG_PAT_BYTES: cfg_pat = value;
      sbss_pkg::REG_PAT_OFFS:  cfg_offs = value;
      sbss_pkg::REG_PAT_COUNT: cfg_count = value[3:0];
      sbss_pkg::REG_LIMIT:     cfg_limit = value[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  step_row_t directed_rows [0:33] = '{
    // reset settings: byte 00 at offset 0, only position 0
    byte_row(8'h00, 1'b0, OUT_HIT, 64'h0),
    byte_row(8'hFF, 1'b1, OUT_NONE, 64'h0),
    byte_row(8'hFF, 1'b1, OUT_MISS, 64'h0),
    // count zero acts as one entry; unused entries carry large offsets
    cfg_row(sbss_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF),
    cfg_row(sbss_pkg::REG_PAT_BYTES, 64'h0102_0304_0506_0708),
    cfg_row(sbss_pkg::REG_PAT_OFFS, 64'hFFFF_FFFF_FFFF_FF02),
    cfg_row(sbss_pkg::REG_PAT_COUNT, 64'h0),
    cfg_row(sbss_pkg::REG_LIMIT, 64'hFFFF_FFFF),
    cfg_row(REG_SPARE_FIRST, 64'hFFFF_FFFF_FFFF_FFFF),
    byte_row(8'h11, 1'b0, OUT_NONE, 64'h0),
    byte_row(8'h22, 1'b0, OUT_NONE, 64'h0),
    byte_row(8'h08, 1'b0, OUT_HIT, 64'hFFFF_FFFF_FFFF_FFFF),
    byte_row(8'h00, 1'b1, OUT_NONE, 64'h0),
    // hit on the final byte, address wraps to zero
    byte_row(8'h00, 1'b0, OUT_NONE, 64'h0),
    byte_row(8'h00, 1'b0, OUT_NONE, 64'h0),
    byte_row(8'h00, 1'b0, OUT_NONE, 64'h0),
    byte_row(8'h08, 1'b1, OUT_HIT, 64'h0),
    // count above the maximum clamps to all eight entries
    cfg_row(sbss_pkg::REG_PAT_COUNT, 64'hF),
    cfg_row(sbss_pkg::REG_PAT_OFFS, 64'h0706_0504_0302_0100),
    cfg_row(sbss_pkg::REG_BASE, 64'h8000_0000_0000_0000),
    byte_row(8'h08, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h07, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h06, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h05, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h04, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h03, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h02, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h01, 1'b1, OUT_HIT, 64'h8000_0000_0000_0000),
    // match lies past the search limit
    cfg_row(sbss_pkg::REG_PAT_COUNT, 64'h1),
    cfg_row(sbss_pkg::REG_PAT_OFFS, 64'h0),
    cfg_row(sbss_pkg::REG_LIMIT, 64'h0),
    cfg_row(REG_SPARE_LAST, 64'h5A5A_5A5A_5A5A_5A5A),
    byte_row(8'h55, 1'b0, OUT_MODEL, 64'h0),
    byte_row(8'h08, 1'b1, OUT_MISS, 64'h0)
  };

  always @(negedge clk)
    out_tready <= !rst_n || steady || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0b match_address %h", out_tuser[0], out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata !== want.addr) begin
          $error("match_address: expected %h, got %h", want.addr, out_tdata);
          fail_count++;
        end
        if (want.found) hits_seen++;
        else misses_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int unsigned rand_items;
    int unsigned streams;
    int unsigned len;
    int unsigned plant;
    int unsigned n_use;
    int unsigned maxoff;
    int unsigned sel;
    int unsigned k;
    int unsigned i;
    bit wide;
    bit was_wide;
    logic [3:0] count_val;
    logic [63:0] offs_val;
    logic [63:0] pat_val;
    logic [63:0] base_val;
    logic [31:0] limit_val;
    logic [7:0] stream_buf [0:299];

    rand_items = 0;
    streams = 0;
    was_wide = 1'b0;
    n_use = 1;
    maxoff = 0;
    pat_val = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        send_byte(directed_rows[r].value[7:0], directed_rows[r].last,
                  directed_rows[r].how, directed_rows[r].addr);
      end
    end

    while (rand_items < RANDOM_ITEMS) begin
      steady = (rand_items >= 300 && rand_items < 450);
      if (streams == 0 || was_wide || $urandom_range(99) < 30) begin
        // first setting of the random part always reaches the furthest offset
        wide = (streams == 0) || (rand_items < 500 && $urandom_range(99) < 6);
        sel = $urandom_range(99);
        count_val = (sel < 6) ? 4'd0 : (sel < 12) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(1, 8));
        n_use = (count_val == 0) ? 1 : (count_val > PATTERN_MAX) ? PATTERN_MAX : count_val;
        for (k = 0; k < PATTERN_MAX; k++)
          offs_val[8*k +: 8] = (k >= n_use || wide) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(12));
        if (wide) begin
          k = $urandom_range(n_use - 1);
          offs_val[8*k +: 8] = 8'hFF;
        end
        pat_val = {$urandom, $urandom};
        sel = $urandom_range(99);
        base_val = (sel < 10) ? 64'h0 : (sel < 20) ? '1 : {$urandom, $urandom};
        sel = $urandom_range(99);
        limit_val = (sel < 10) ? 32'h0 : (sel < 25) ? '1 : (sel < 35) ? $urandom
                                                  : 32'($urandom_range(40));
        wait_idle();
        write_reg(sbss_pkg::REG_BASE, base_val);
        write_reg(sbss_pkg::REG_PAT_BYTES, pat_val);
        write_reg(sbss_pkg::REG_PAT_OFFS, offs_val);
        write_reg(sbss_pkg::REG_PAT_COUNT, {60'b0, count_val});
        write_reg(sbss_pkg::REG_LIMIT, {32'b0, limit_val});
        if ($urandom_range(99) < 20)
          write_reg(REG_SPARE_FIRST + 3'($urandom_range(2)), {$urandom, $urandom});
        maxoff = 0;
        for (k = 0; k < n_use; k++)
          if (offs_val[8*k +: 8] > maxoff) maxoff = offs_val[8*k +: 8];
        was_wide = wide;
      end

      len = (maxoff >= 40) ? maxoff + $urandom_range(1, 40) : $urandom_range(1, maxoff + 24);
      // background leans on pattern bytes so that near misses are common
      for (i = 0; i < len; i++)
        stream_buf[i] = ($urandom_range(99) < 40) ? pat_val[8*$urandom_range(n_use - 1) +: 8]
                                                  : 8'($urandom);
      if (len > maxoff && $urandom_range(99) < 75) begin
        repeat ($urandom_range(1, 2)) begin
          plant = $urandom_range(len - 1 - maxoff);
          for (k = 0; k < n_use; k++)
            stream_buf[plant + offs_val[8*k +: 8]] = pat_val[8*k +: 8];
        end
        if ($urandom_range(99) < 15) begin
          k = $urandom_range(n_use - 1);
          stream_buf[plant + offs_val[8*k +: 8]] ^= 8'(1 << $urandom_range(7));
        end
      end
      for (i = 0; i < len; i++) begin
        rand_items++;
        send_byte(stream_buf[i], i == len - 1, OUT_MODEL, 64'h0);
      end
      streams++;
    end

    steady = 1'b0;
    wait_idle();
    $display("summary: %0d bytes in %0d streams, %0d hits and %0d not-found results compared",
             bytes_sent, streams_done, hits_seen, misses_seen);
    if (fail_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sbss_pkg.sv
src/sbss_cfg.sv
src/sbss_cell.sv
src/sparse_byte_signature_scan_top.sv
tb/testbench.sv
